// File: sv/bitmap_frame_allocator_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap frame allocator
// Concurrent checks clocked on the rising edge and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BITMAP_FRAME_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_FRAME_ALLOCATOR_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every edge outside reset
`define FAM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition must never be seen outside reset
`define FAM_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define FAM_ASSERT(lbl, clk, rstn, prop, msg)
`define FAM_ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

// File: sv/fam_pkg.sv
// ----------------------------------------------------------------------------
// fam_pkg
// Shared constants, types and helpers of the bitmap frame allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fam_pkg;

  localparam int unsigned ADDR_W        = 32;
  localparam int unsigned FRAME_SHIFT   = 12;
  localparam int unsigned FRAME_W       = ADDR_W - FRAME_SHIFT;
  localparam int unsigned NUM_FRAMES    = 1048576;
  localparam int unsigned MAP_WORD_BITS = 32;
  localparam int unsigned BIT_W         = $clog2(MAP_WORD_BITS);
  localparam int unsigned MAP_WORDS     = (NUM_FRAMES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int unsigned WORD_IDX_W    = $clog2(MAP_WORDS);
  localparam int unsigned COUNT_W       = 21;
  localparam int unsigned OUT_DATA_W    = 80;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_ALLOC      = 2'd0,
    OP_FREE       = 2'd1,
    OP_MAKE_AVAIL = 2'd2,
    OP_RESERVE    = 2'd3
  } fam_op_e;

  // Map memory request, one write and one read port
  typedef struct packed {
    logic                     wr_en;
    logic [WORD_IDX_W-1:0]    wr_addr;
    logic [MAP_WORD_BITS-1:0] wr_data;
    logic                     rd_en;
    logic [WORD_IDX_W-1:0]    rd_addr;
  } fam_mem_req_t;

  // One result word
  typedef struct packed {
    logic [COUNT_W-1:0] used_count;
    logic [COUNT_W-1:0] total_count;
    logic               ok;
    logic [ADDR_W-1:0]  frame_address;
  } fam_result_t;

  // Lowest clear bit of a map word
  function automatic logic [BIT_W-1:0] first_zero(input logic [MAP_WORD_BITS-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

  // Increment that sticks at the counter maximum
  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v == COUNT_MAX) ? COUNT_MAX : v + COUNT_W'(1);
  endfunction

endpackage

`default_nettype wire

// File: sv/bitmap_frame_allocator_unit.sv
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_unit
// First-fit 4KB frame allocator over a one-bit-per-frame used map.
// Operation: a free, make-available or reserve word reads its map word, writes
//   it back in the RMW state and gives its result word; alloc reads map words
//   in turn from a hint below which every word is known to be full.
// Flow: a new word is taken only once the last result has gone to the output
//   register; a stalled output holds input.
// Reset: a clearing pass writes all 32768 map words and marks every frame used;
//   no word is taken during it. Counters reset to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_frame_allocator_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  input  wire logic [fam_pkg::ADDR_W-1:0]        s_axis_tdata_i,  // address
  input  wire logic [1:0]                        s_axis_tuser_i,  // opcode
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // frame_address[31:0], ok[32], total_count[53:33], used_count[74:54], zeros
  output logic      [fam_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o
);

  import fam_pkg::*;

  fam_mem_req_t             mem_req;
  logic [MAP_WORD_BITS-1:0] mem_rdata;
  logic                     res_valid;
  logic                     res_ready;
  fam_result_t              res;
  logic                     out_valid_q, out_valid_d;
  fam_result_t              out_data_q;

  fam_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_op_i      (fam_op_e'(s_axis_tuser_i)),
    .in_address_i (s_axis_tdata_i),
    .mem_req_o    (mem_req),
    .mem_rdata_i  (mem_rdata),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  fam_map_ram #(
    .DEPTH (MAP_WORDS),
    .WIDTH (MAP_WORD_BITS)
  ) u_map_ram (
    .clk_i     (clk_i),
    .wr_en_i   (mem_req.wr_en),
    .wr_addr_i (mem_req.wr_addr),
    .wr_data_i (mem_req.wr_data),
    .rd_en_i   (mem_req.rd_en),
    .rd_addr_i (mem_req.rd_addr),
    .rd_data_o (mem_rdata)
  );

  // Output register: take a result when empty or being drained
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_DATA_W'(out_data_q);

endmodule

`default_nettype wire

// File: sv/fam_map_ram.sv
// ----------------------------------------------------------------------------
// fam_map_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fam_map_ram #(
  parameter int unsigned DEPTH = 32768,
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// File: sv/fam_ctrl.sv
// ----------------------------------------------------------------------------
// fam_ctrl
// Sequencer of the frame allocator: clearing pass, read-modify-write of one
// map word, first-fit scan, counters and the free-word hint.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bitmap_frame_allocator_unit_macros.svh"

module fam_ctrl (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire fam_pkg::fam_op_e                  in_op_i,
  input  wire logic [fam_pkg::ADDR_W-1:0]        in_address_i,
  output fam_pkg::fam_mem_req_t                  mem_req_o,
  input  wire logic [fam_pkg::MAP_WORD_BITS-1:0] mem_rdata_i,
  output logic                                   res_valid_o,
  input  wire logic                              res_ready_i,
  output fam_pkg::fam_result_t                   res_o
);

  import fam_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_RMW   = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_RESP  = 5'b10000
  } fam_state_e;

  localparam logic [WORD_IDX_W-1:0] LAST_WORD = WORD_IDX_W'(MAP_WORDS - 1);

  fam_state_e             state_q, state_d;
  logic [WORD_IDX_W-1:0]  clr_ptr_q, clr_ptr_d;
  logic [WORD_IDX_W-1:0]  ptr_q, ptr_d;
  logic [WORD_IDX_W-1:0]  hint_q, hint_d;
  logic                   hint_none_q, hint_none_d;
  logic [COUNT_W-1:0]     total_q, total_d;
  logic [COUNT_W-1:0]     used_q, used_d;
  fam_op_e                op_q, op_d;
  logic [FRAME_W-1:0]     frame_q, frame_d;
  logic [ADDR_W-1:0]      res_addr_q, res_addr_d;
  logic                   res_ok_q, res_ok_d;

  logic [FRAME_W-1:0]       in_frame;
  logic                     in_range;
  logic [WORD_IDX_W-1:0]    in_widx;
  logic [WORD_IDX_W-1:0]    cur_widx;
  logic [BIT_W-1:0]         cur_bit;
  logic [MAP_WORD_BITS-1:0] cur_mask;
  logic                     cur_used;
  logic [BIT_W-1:0]         free_bit;
  logic [MAP_WORD_BITS-1:0] free_mask;

  // Decode the incoming byte address
  assign in_frame = in_address_i[ADDR_W-1:FRAME_SHIFT];
  assign in_range = (FRAME_W + 1)'(in_frame) < (FRAME_W + 1)'(NUM_FRAMES);
  assign in_widx  = WORD_IDX_W'(in_frame >> BIT_W);

  // Bit addressed by the held item within the word just read
  assign cur_widx = WORD_IDX_W'(frame_q >> BIT_W);
  assign cur_bit  = frame_q[BIT_W-1:0];
  assign cur_mask = MAP_WORD_BITS'(1) << cur_bit;
  assign cur_used = mem_rdata_i[cur_bit];

  // First clear bit of a scanned word
  assign free_bit  = first_zero(mem_rdata_i);
  assign free_mask = MAP_WORD_BITS'(1) << free_bit;

  // Next-state and datapath
  always_comb begin
    state_d     = state_q;
    clr_ptr_d   = clr_ptr_q;
    ptr_d       = ptr_q;
    hint_d      = hint_q;
    hint_none_d = hint_none_q;
    total_d     = total_q;
    used_d      = used_q;
    op_d        = op_q;
    frame_d     = frame_q;
    res_addr_d  = res_addr_q;
    res_ok_d    = res_ok_q;
    mem_req_o   = '0;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        // Mark every frame used, one word a cycle
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_addr = clr_ptr_q;
        mem_req_o.wr_data = '1;
        clr_ptr_d         = clr_ptr_q + WORD_IDX_W'(1);
        if (clr_ptr_q == LAST_WORD) begin
          hint_none_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d       = in_op_i;
          frame_d    = in_frame;
          res_addr_d = '0;
          res_ok_d   = 1'b0;
          if (in_op_i == OP_ALLOC) begin
            if (hint_none_q) begin
              state_d = ST_RESP;
            end else begin
              mem_req_o.rd_en   = 1'b1;
              mem_req_o.rd_addr = hint_q;
              ptr_d             = hint_q;
              state_d           = ST_SCAN;
            end
          end else if (in_range) begin
            mem_req_o.rd_en   = 1'b1;
            mem_req_o.rd_addr = in_widx;
            state_d           = ST_RMW;
          end else begin
            state_d = ST_RESP;
          end
        end
      end

      ST_RMW: begin
        // Flip the addressed bit if it is not already in the target state
        unique case (op_q) inside
          OP_FREE, OP_MAKE_AVAIL: begin
            if (cur_used) begin
              mem_req_o.wr_en   = 1'b1;
              mem_req_o.wr_addr = cur_widx;
              mem_req_o.wr_data = mem_rdata_i & ~cur_mask;
              res_ok_d          = 1'b1;
              if (hint_none_q || (cur_widx < hint_q)) begin
                hint_d      = cur_widx;
                hint_none_d = 1'b0;
              end
              if (op_q == OP_FREE) begin
                if (used_q != '0) begin
                  used_d = used_q - COUNT_W'(1);
                end
              end else begin
                total_d = sat_inc(total_q);
              end
            end
          end
          OP_RESERVE: begin
            if (!cur_used) begin
              mem_req_o.wr_en   = 1'b1;
              mem_req_o.wr_addr = cur_widx;
              mem_req_o.wr_data = mem_rdata_i | cur_mask;
              res_ok_d          = 1'b1;
              used_d            = sat_inc(used_q);
            end
          end
          default: begin
          end
        endcase
        state_d = ST_RESP;
      end

      ST_SCAN: begin
        // Stream reads ahead; data now belongs to ptr_q
        mem_req_o.rd_en   = 1'b1;
        mem_req_o.rd_addr = ptr_q + WORD_IDX_W'(1);
        if (mem_rdata_i != '1) begin
          mem_req_o.wr_en   = 1'b1;
          mem_req_o.wr_addr = ptr_q;
          mem_req_o.wr_data = mem_rdata_i | free_mask;
          used_d            = sat_inc(used_q);
          res_addr_d        = ADDR_W'({ptr_q, free_bit}) << FRAME_SHIFT;
          res_ok_d          = 1'b1;
          hint_d            = ptr_q;
          state_d           = ST_RESP;
        end else if (ptr_q == LAST_WORD) begin
          hint_none_d = 1'b1;
          state_d     = ST_RESP;
        end else begin
          ptr_d = ptr_q + WORD_IDX_W'(1);
        end
      end

      ST_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_ptr_q   <= '0;
      hint_none_q <= 1'b1;
      total_q     <= '0;
      used_q      <= '0;
    end else begin
      state_q     <= state_d;
      clr_ptr_q   <= clr_ptr_d;
      hint_none_q <= hint_none_d;
      total_q     <= total_d;
      used_q      <= used_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ptr_q      <= ptr_d;
    hint_q     <= hint_d;
    op_q       <= op_d;
    frame_q    <= frame_d;
    res_addr_q <= res_addr_d;
    res_ok_q   <= res_ok_d;
  end

  assign res_o.frame_address = res_addr_q;
  assign res_o.ok            = res_ok_q;
  assign res_o.total_count   = total_q;
  assign res_o.used_count    = used_q;

  `FAM_ASSERT_NEVER(a_no_write_on_accept, clk_i, rst_ni, mem_req_o.wr_en && in_valid_i && in_ready_o, "map write while taking a word")
  `FAM_ASSERT(a_scan_continues, clk_i, rst_ni, (state_q == ST_SCAN && mem_rdata_i == '1 && ptr_q != LAST_WORD) |=> (state_q == ST_SCAN), "scan stopped on a full word")
  `FAM_ASSERT(a_rmw_ok, clk_i, rst_ni, (state_q == ST_RMW) |=> (state_q == ST_RESP && res_o.ok == $past(mem_req_o.wr_en)), "ok does not match map update")
  `FAM_ASSERT(a_clear_done, clk_i, rst_ni, (state_q == ST_CLEAR && state_d == ST_IDLE) |=> hint_none_q, "free hint live after clearing pass")

endmodule

`default_nettype wire

// File: dv/fam_checker.sv
// ----------------------------------------------------------------------------
// fam_checker
// Watches both stream channels of the frame allocator, keeps its own copy of
// the used map and counters, predicts one result word per accepted word and
// compares every delivered result with the oldest prediction.
// ----------------------------------------------------------------------------
module fam_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  input  logic                           s_tready_i,
  input  logic [fam_pkg::ADDR_W-1:0]     s_tdata_i,
  input  logic [1:0]                     s_tuser_i,
  input  logic                           m_tvalid_i,
  input  logic                           m_tready_i,
  input  logic [fam_pkg::OUT_DATA_W-1:0] m_tdata_i,
  output int unsigned                    fail_count_o,
  output int unsigned                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import fam_pkg::*;

  localparam int unsigned RESULT_W = $bits(fam_result_t);

  // Shadow used map (1 = used) and counters
  bit [MAP_WORD_BITS-1:0] frame_words [MAP_WORDS];
  bit [COUNT_W-1:0]       avail_total;
  bit [COUNT_W-1:0]       in_use_total;
  // Every word below this index is known to be full
  int unsigned            low_word;

  fam_result_t            expected_results [$];
  int unsigned            fail_count;

  // Count up, sticking at the top
  function automatic bit [COUNT_W-1:0] count_up(input bit [COUNT_W-1:0] v);
    return (v == {COUNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  // Apply one word to the shadow map and return the result it should give
  function automatic fam_result_t predict_frame_op(input fam_op_e op,
                                                   input logic [ADDR_W-1:0] addr);
    fam_result_t r;
    int unsigned frame;
    int unsigned w;
    int unsigned b;
    int unsigned f;
    bit          in_range;
    bit          hit;
    r        = '0;
    frame    = addr >> FRAME_SHIFT;
    w        = frame / MAP_WORD_BITS;
    b        = frame % MAP_WORD_BITS;
    in_range = frame < NUM_FRAMES;
    hit      = 1'b0;
    case (op)
      OP_ALLOC: begin
        // First fit: lowest free frame, skipping the full words at the bottom
        for (int unsigned i = low_word; i < MAP_WORDS && !hit; i++) begin
          if (frame_words[i] != '1) begin
            for (int unsigned j = 0; j < MAP_WORD_BITS && !hit; j++) begin
              f = i * MAP_WORD_BITS + j;
              if (!frame_words[i][j] && f < NUM_FRAMES) begin
                frame_words[i][j] = 1'b1;
                in_use_total      = count_up(in_use_total);
                r.frame_address   = ADDR_W'(f << FRAME_SHIFT);
                r.ok              = 1'b1;
                hit               = 1'b1;
                low_word          = i;
              end
            end
          end
        end
        if (!hit) begin
          low_word = MAP_WORDS;
        end
      end
      OP_FREE: begin
        if (in_range && frame_words[w][b]) begin
          frame_words[w][b] = 1'b0;
          if (in_use_total != 0) begin
            in_use_total = in_use_total - 1'b1;
          end
          r.ok = 1'b1;
          if (w < low_word) begin
            low_word = w;
          end
        end
      end
      OP_MAKE_AVAIL: begin
        if (in_range && frame_words[w][b]) begin
          frame_words[w][b] = 1'b0;
          avail_total       = count_up(avail_total);
          r.ok              = 1'b1;
          if (w < low_word) begin
            low_word = w;
          end
        end
      end
      default: begin
        if (in_range && !frame_words[w][b]) begin
          frame_words[w][b] = 1'b1;
          in_use_total      = count_up(in_use_total);
          r.ok              = 1'b1;
        end
      end
    endcase
    r.total_count = avail_total;
    r.used_count  = in_use_total;
    return r;
  endfunction

  // Print one line per mismatch and count it
  task automatic flag_error(input string what, input logic [ADDR_W-1:0] got,
                            input logic [ADDR_W-1:0] want);
    $display("ERROR at %0t ns: %s got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    fail_count++;
  endtask

  // Predict on every accepted input word, compare on every accepted result word
  always @(posedge clk_i or negedge rst_ni) begin
    fam_result_t got;
    fam_result_t want;
    if (!rst_ni) begin
      foreach (frame_words[i]) begin
        frame_words[i] = '1;
      end
      avail_total  = '0;
      in_use_total = '0;
      low_word     = 0;
      expected_results.delete();
      pending_o <= 0;
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        expected_results.push_back(predict_frame_op(fam_op_e'(s_tuser_i), s_tdata_i));
      end
      if (m_tvalid_i && m_tready_i) begin
        if (expected_results.size() == 0) begin
          flag_error("unexpected result word", m_tdata_i[ADDR_W-1:0], '0);
        end else begin
          want = expected_results.pop_front();
          got  = fam_result_t'(m_tdata_i[RESULT_W-1:0]);
          if (got.frame_address !== want.frame_address) begin
            flag_error("frame_address", got.frame_address, want.frame_address);
          end
          if (got.ok !== want.ok) begin
            flag_error("ok", ADDR_W'(got.ok), ADDR_W'(want.ok));
          end
          if (got.total_count !== want.total_count) begin
            flag_error("total_count", ADDR_W'(got.total_count), ADDR_W'(want.total_count));
          end
          if (got.used_count !== want.used_count) begin
            flag_error("used_count", ADDR_W'(got.used_count), ADDR_W'(want.used_count));
          end
          if (m_tdata_i[OUT_DATA_W-1:RESULT_W] !== '0) begin
            flag_error("padding bits", ADDR_W'(m_tdata_i[OUT_DATA_W-1:RESULT_W]), '0);
          end
        end
      end
      pending_o <= expected_results.size();
    end
    fail_count_o <= fail_count;
  end

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the bitmap frame allocator with a directed opening (empty-map alloc,
// frame 0, top frame, repeated set-up, free with a zero used count) and then
// about a thousand random words in a small frame window, with random gaps on
// the input and random stalls on the output. The checker does the prediction.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fam_pkg::*;

  localparam int unsigned RANDOM_WORDS = 1000;
  localparam int unsigned WIN_FRAMES   = 256;
  localparam int unsigned QUIET_LIMIT  = 200000;
  localparam int unsigned TAIL_CYCLES  = 40;
  localparam int unsigned DIRECTED_N   = 24;

  logic                  clk_i    = 1'b0;
  logic                  rst_ni   = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic [ADDR_W-1:0]     s_tdata  = '0;
  logic [1:0]            s_tuser  = '0;
  logic                  s_tready;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  int unsigned fails;
  int unsigned pending;
  int unsigned stall_left  = 0;
  int unsigned idle_cycles = 0;
  bit          send_gaps    = 1'b1;
  bit          drain_stalls = 1'b1;

  // Rough view of which frames are free, only to steer allocs away from an
  // empty map in the random part (a failed alloc can scan to the end of the map)
  bit          win_used [WIN_FRAMES] = '{default: 1'b1};
  bit          far_free [int unsigned];

  always #5 clk_i = ~clk_i;

  bitmap_frame_allocator_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  fam_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  // Mostly short gaps, now and then a long one
  function automatic int unsigned gap_length();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  // Keep the free-frame view in step with what is sent
  function automatic void track_word(input fam_op_e op, input logic [ADDR_W-1:0] addr);
    int unsigned frame;
    int unsigned key;
    bit          done;
    frame = addr >> FRAME_SHIFT;
    done  = 1'b0;
    case (op)
      OP_ALLOC: begin
        for (int unsigned i = 0; i < WIN_FRAMES && !done; i++) begin
          if (!win_used[i]) begin
            win_used[i] = 1'b1;
            done        = 1'b1;
          end
        end
        if (!done && far_free.first(key)) begin
          far_free.delete(key);
        end
      end
      OP_FREE, OP_MAKE_AVAIL: begin
        if (frame < WIN_FRAMES) begin
          win_used[frame] = 1'b0;
        end else begin
          far_free[frame] = 1'b1;
        end
      end
      default: begin
        if (frame < WIN_FRAMES) begin
          win_used[frame] = 1'b1;
        end else if (far_free.exists(frame)) begin
          far_free.delete(frame);
        end
      end
    endcase
  endfunction

  function automatic bit has_free_frame();
    bit any;
    any = far_free.num() != 0;
    foreach (win_used[i]) begin
      if (!win_used[i]) begin
        any = 1'b1;
      end
    end
    return any;
  endfunction

  // Offer one word, optionally after a gap, and hold it until accepted
  task automatic send_word(input fam_op_e op, input logic [ADDR_W-1:0] addr);
    int unsigned gap;
    gap = (send_gaps && $urandom_range(0, 99) < 30) ? gap_length() : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= addr;
    track_word(op, addr);
    do @(posedge clk_i); while (!s_tready);
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Output side back-pressure
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      if (drain_stalls && $urandom_range(0, 99) < 25) begin
        stall_left <= gap_length();
      end
    end
  end

  // Abort when no word moves on either side for too long
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= QUIET_LIMIT) begin
      $display("bitmap_frame_allocator_unit test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus
  initial begin
    fam_op_e           dir_ops   [DIRECTED_N];
    logic [ADDR_W-1:0] dir_addrs [DIRECTED_N];
    fam_op_e           op;
    logic [ADDR_W-1:0] addr;
    int unsigned       roll;
    int unsigned       phase;

    // Empty map, free with zero used count, repeats, frame 0, top frame
    dir_ops = '{OP_ALLOC, OP_FREE, OP_MAKE_AVAIL, OP_RESERVE, OP_MAKE_AVAIL,
                OP_MAKE_AVAIL, OP_ALLOC, OP_RESERVE, OP_MAKE_AVAIL, OP_FREE,
                OP_RESERVE, OP_FREE, OP_RESERVE, OP_RESERVE, OP_MAKE_AVAIL,
                OP_MAKE_AVAIL, OP_MAKE_AVAIL, OP_ALLOC, OP_ALLOC, OP_FREE,
                OP_ALLOC, OP_ALLOC, OP_ALLOC, OP_FREE};
    dir_addrs = '{32'h1234_5678, 32'h0006_4000, 32'h0006_4ABC, 32'h0006_4FFF,
                  32'h0000_0000, 32'h0000_0FFF, 32'hFFFF_FFFF, 32'h0000_0000,
                  32'hFFFF_FFFF, 32'hFFFF_F000, 32'hFFFF_F123, 32'hAAAA_A555,
                  32'h5555_5AAA, 32'hAAAA_AFFF, 32'h0000_1000, 32'h0000_2000,
                  32'h0000_3000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_1800,
                  32'h8000_0001, 32'h7FFF_FFFE, 32'h0000_0000, 32'h0000_0000};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int unsigned i = 0; i < DIRECTED_N; i++) begin
      send_word(dir_ops[i], dir_addrs[i]);
    end
    drain_results();

    // Random part in four phases of idling: both, none, input only, output only
    for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
      if (n % (RANDOM_WORDS / 4) == 0) begin
        phase         = n / (RANDOM_WORDS / 4);
        send_gaps     = (phase == 0) || (phase == 2);
        drain_stalls <= (phase == 0) || (phase == 3);
      end
      if (n == RANDOM_WORDS / 2) begin
        drain_results();
      end
      if ($urandom_range(0, 99) == 0) begin
        // Rare set-up or free anywhere in the address space
        op   = fam_op_e'($urandom_range(OP_FREE, OP_RESERVE));
        addr = $urandom();
      end else begin
        roll = $urandom_range(0, 99);
        op   = (roll < 35) ? OP_ALLOC :
               (roll < 55) ? OP_FREE :
               (roll < 85) ? OP_MAKE_AVAIL : OP_RESERVE;
        addr = (ADDR_W'($urandom_range(0, WIN_FRAMES - 1)) << FRAME_SHIFT) |
               ADDR_W'($urandom_range(0, (1 << FRAME_SHIFT) - 1));
        if (op == OP_ALLOC) begin
          if (!has_free_frame()) begin
            op = OP_MAKE_AVAIL;
          end else begin
            addr = $urandom();
          end
        end
      end
      send_word(op, addr);
    end
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fails == 0 && pending == 0) begin
      $display("bitmap_frame_allocator_unit test passed");
    end else begin
      $display("bitmap_frame_allocator_unit test failed");
    end
    $finish;
  end

endmodule
